>>> hw/rtl/md5_pkg.sv
// Package: MD5 constants, tables and round helpers.
package md5_pkg;
  localparam int WordW = 32;
  localparam int LenW  = 61;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] l;
    l = i[3:0];
    unique case (i[5:4])
      2'd0: g = l;
      2'd1: g = 4'(5 * l + 1);
      2'd2: g = 4'(3 * l + 5);
      default: g = 4'(7 * l);
    endcase
    return g;
  endfunction
endpackage

>>> hw/rtl/md5_if.sv
// Interfaces: input word channel and digest channel.
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        final_word;
  modport source (output valid, data_word, byte_count, final_word, input ready);
  modport sink (input valid, data_word, byte_count, final_word, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

>>> hw/rtl/md5_core.sv
// Compression core: one MD5 round per cycle, block words read from a memory.
module md5_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] mem_rdata,
  output logic [3:0]  mem_raddr,
  output logic        done,
  output logic [127:0] chain
);
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] ca_r, cb_r, cc_r, cd_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [5:0]  rnd;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;

  // the word for round cnt is addressed in the cycle before its round; cnt 0 is the prefetch cycle
  assign rnd = 6'(cnt_r - 7'd1);
  assign mem_raddr = round_g(cnt_r[5:0]);
  assign done = done_r;
  assign chain = {cd_r, cc_r, cb_r, ca_r};

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum = f + a_r + round_k(rnd) + mem_rdata;
    sh  = round_s(rnd);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    done_r <= rst_n && busy_r && (cnt_r == 7'd64);
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      ca_r <= InitA; cb_r <= InitB; cc_r <= InitC; cd_r <= InitD;
    end else if (start && !busy_r) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd0;
      a_r <= ca_r; b_r <= cb_r; c_r <= cc_r; d_r <= cd_r;
    end else if (busy_r) begin
      if (cnt_r != 7'd0) begin
        a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
      end
      if (cnt_r == 7'd64) begin
        busy_r <= 1'b0;
        ca_r <= ca_r + d_r;
        cb_r <= cb_r + b_r + rot;
        cc_r <= cc_r + b_r;
        cd_r <= cd_r + c_r;
      end
      cnt_r <= cnt_r + 7'd1;
    end else if (start == 1'b0 && cnt_r == 7'd127) begin
      cnt_r <= '0;
    end
  end

  // chain reinit requested by the top through a start-free window
  // (handled by md5_stream_hash via a separate reset pulse)
endmodule

>>> hw/rtl/md5_stream_hash.sv
// Top level: streaming MD5 with block memory and round-serial compression.
// Each compression runs through start, prefetch, 64 rounds and the done handoff.
// A word is accepted, then its bytes are packed one by one; every 64th byte adds a compression.
// A final word pads (one or two compressions) and then issues four digest beats.
// Synchronous active-low reset restores the initial chaining values.
// The block memory holds no reset; every entry is written before it is read.
module md5_stream_hash import md5_pkg::*; (
  input logic clk,
  input logic rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  localparam logic [2:0] S_IN = 3'd0, S_BYTE = 3'd1, S_COMP = 3'd2, S_PAD = 3'd3,
                         S_LEN = 3'd4, S_OUT = 3'd5, S_WAIT = 3'd6, S_INIT = 3'd7;

  logic [31:0] mem [16];
  logic [31:0] mem_rdata_r;
  logic [3:0]  raddr;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic [2:0]  st_r;
  logic [2:0]  ret_r;
  logic [5:0]  pos_r;
  logic [60:0] len_r;
  logic [31:0] word_r;
  logic [31:0] data_r;
  logic [2:0]  cnt_r;
  logic [2:0]  idx_r;
  logic        fin_r;
  logic        len_done_r;
  logic        start;
  logic        done;
  logic [127:0] chain;
  logic        core_rst_n;
  logic [63:0] bits;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_rdata_r <= mem[raddr];
  end

  assign core_rst_n = rst_n && (st_r != S_INIT);

  md5_core u_core (
    .clk(clk), .rst_n(core_rst_n), .start(start), .mem_rdata(mem_rdata_r),
    .mem_raddr(raddr), .done(done), .chain(chain)
  );

  assign in_ch.ready = (st_r == S_IN);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.digest_word = chain[32*idx_r[1:0] +: 32];
  assign out_ch.digest_last = (idx_r == 3'd3);
  assign bits = {len_r, 3'b000};

  always_comb begin
    logic [31:0] m;
    m = 32'hFF << {pos_r[1:0], 3'b000};
    start = (st_r == S_COMP);
    we    = 1'b0;
    waddr = pos_r[5:2];
    wdata = (word_r & ~m) | ((32'(data_r[7:0]) << {pos_r[1:0], 3'b000}) & m);
    unique case (st_r)
      S_BYTE, S_PAD: we = 1'b1;
      S_LEN: begin
        we = 1'b1;
        waddr = len_done_r ? 4'd15 : 4'd14;
        wdata = len_done_r ? bits[63:32] : bits[31:0];
      end
      default: we = 1'b0;
    endcase
  end

  // word_r shadows the partial word being packed at pos_r[5:2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IN; pos_r <= '0; len_r <= '0; idx_r <= '0;
      ret_r <= S_IN; fin_r <= 1'b0; len_done_r <= 1'b0; cnt_r <= '0;
    end else begin
      unique case (st_r)
        S_IN: if (in_ch.valid) begin
          cnt_r  <= (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
          fin_r  <= in_ch.final_word;
          if (in_ch.final_word && in_ch.byte_count == 3'd0) data_r <= 32'h80;
          else data_r <= in_ch.data_word;
          if (in_ch.byte_count == 3'd0) st_r <= in_ch.final_word ? S_PAD : S_IN;
          else st_r <= S_BYTE;
        end
        S_BYTE: begin
          word_r <= (pos_r[1:0] == 2'd3) ? 32'd0 : wdata;
          pos_r  <= pos_r + 6'd1;
          len_r  <= len_r + 61'd1;
          data_r <= (cnt_r == 3'd1 && fin_r) ? 32'h80 : {8'd0, data_r[31:8]};
          cnt_r  <= cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            if (pos_r == 6'd63) begin
              st_r <= S_COMP; ret_r <= fin_r ? S_PAD : S_IN;
            end else st_r <= fin_r ? S_PAD : S_IN;
          end else if (pos_r == 6'd63) begin
            st_r <= S_COMP; ret_r <= S_BYTE;
          end
        end
        S_PAD: begin
          word_r <= (pos_r[1:0] == 2'd3) ? 32'd0 : wdata;
          pos_r  <= pos_r + 6'd1;
          data_r <= 32'd0;
          if (pos_r == 6'd63) begin
            st_r <= S_COMP; ret_r <= S_PAD;
          end else if (pos_r == 6'd55) st_r <= S_LEN;
        end
        S_LEN: begin
          len_done_r <= ~len_done_r;
          if (len_done_r) begin
            st_r <= S_COMP; ret_r <= S_OUT; pos_r <= '0;
          end
        end
        S_COMP: st_r <= S_WAIT;
        S_WAIT: if (done) begin
          st_r <= ret_r; idx_r <= '0;
        end
        S_OUT: if (out_ch.ready) begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd3) st_r <= S_INIT;
        end
        default: begin
          st_r <= S_IN; pos_r <= '0; len_r <= '0; word_r <= '0;
        end
      endcase
    end
  end
endmodule

>>> bench/md5_stream_hash_sb.sv
// Scoreboard: MD5 digest prediction and digest beat checking.
`timescale 1ns / 1ps
package md5_stream_hash_sb_pkg;
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  class md5_digest_board;
    logic [31:0]  chain[4];
    logic [31:0]  blk[16];
    int unsigned  pos;
    logic [60:0]  msg_len;
    digest_beat_t digests[$];
    int unsigned  errors;
    int unsigned  beats_checked;
    int unsigned  messages;

    function new();
      errors = 0;
      beats_checked = 0;
      messages = 0;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      pos = 0;
      msg_len = '0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t;
      int unsigned q, g;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
        q = i / 16;
        case (q)
          0: begin f = (b & c) | (~b & d); g = i; end
          1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
          2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
          default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
        endcase
        f = f + a + ktab(i) + blk[g];
        a = d; d = c; c = b;
        t = (f << stab(q * 4 + i % 4)) | (f >> (32 - stab(q * 4 + i % 4)));
        b = b + t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function int unsigned stab(int unsigned n);
      int unsigned s[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      return s[n];
    endfunction

    function logic [31:0] ktab(int unsigned n);
      logic [31:0] k[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[n];
    endfunction

    function void pack_byte(logic [7:0] v);
      blk[pos / 4][(pos % 4) * 8 +: 8] = v;
      pos = (pos + 1) % 64;
      if (pos == 0) compress();
    endfunction

    function void note_word(logic [31:0] data, logic [2:0] count, logic fin);
      int unsigned n;
      logic [63:0] bits;
      n = (count > 4) ? 4 : count;
      for (int k = 0; k < n; k++) begin
        pack_byte(data[k * 8 +: 8]);
        msg_len = msg_len + 1;
      end
      if (!fin) return;
      bits = {msg_len, 3'b000};
      pack_byte(8'h80);
      while (pos != 56) pack_byte(8'h00);
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress();
      for (int k = 0; k < 4; k++) digests.push_back('{chain[k], k == 3});
      messages++;
      restart();
    endfunction

    function void check_beat(logic [31:0] word, logic last);
      digest_beat_t exp;
      if (digests.size() == 0) begin
        $display("%0t: unexpected digest beat %h last %b", $realtime, word, last);
        errors++;
        return;
      end
      exp = digests.pop_front();
      beats_checked++;
      if (word !== exp.word) begin
        $display("%0t: digest_word expected %h actual %h", $realtime, exp.word, word);
        errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: digest_last expected %b actual %b", $realtime, exp.last, last);
        errors++;
      end
    endfunction
  endclass
endpackage

>>> bench/md5_stream_hash_tb.sv
// Testbench top: drives message words into md5_stream_hash and checks digests.
`timescale 1ns / 1ps
module md5_stream_hash_tb;
  import md5_stream_hash_sb_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  md5_in_if  in_ch();
  md5_out_if out_ch();
  md5_digest_board board = new();
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  bit calm = 1'b0;
  bit hold_sink = 1'b0;
  bit stim_done = 1'b0;

  md5_stream_hash DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.final_word = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_beat(out_ch.digest_word, out_ch.digest_last);
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_sink && (calm || $urandom_range(99) >= 7);
  end

  task automatic send_word(logic [31:0] data, logic [2:0] count, logic fin);
    while (!calm && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= data;
    in_ch.byte_count <= count;
    in_ch.final_word <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(data, count, fin);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned full_words);
    for (int i = 0; i < full_words; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'($urandom_range(4)), 1'b1);
  endtask

  initial begin
    wait (rst_n);
    @(negedge clk);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h00636261, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h12345678, 3'd0, 1'b0);
    send_word(32'hdeadbeef, 3'd2, 1'b0);
    send_word(32'ha5a5a5a5, 3'd7, 1'b0);
    send_word(32'h5a5a5a5a, 3'd5, 1'b1);
    for (int i = 0; i < 13; i++) send_word(32'h01010101 * i, 3'd4, 1'b0);
    send_word(32'hffffff00, 3'd3, 1'b1);
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_message(2);
        send_message(0);
        send_message(0);
        send_message(3);
      end
    join
    calm = 1'b1;
    send_message(20);
    calm = 1'b0;
    while (words_sent < 370) begin
      if ($urandom_range(9) == 0)
        send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
      else
        send_message($urandom_range(3) == 0 ? $urandom_range(33) : $urandom_range(14));
    end
    send_word($urandom, 3'd4, 1'b1);
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (board.digests.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d words in %0d messages; checked %0d digest beats.",
             words_sent, board.messages, board.beats_checked);
    if (board.errors == 0 && board.digests.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_if.sv
hw/rtl/md5_core.sv
hw/rtl/md5_stream_hash.sv
bench/md5_stream_hash_sb.sv
bench/md5_stream_hash_tb.sv
